[design/qau_pkg.sv]
`timescale 1ns / 1ps
package qau_pkg;
   localparam int CompWidth = 16;
   localparam int FracBits = 14;
   localparam logic [2:0] CMD_PRODUCT = 3'd0;
   localparam logic [2:0] CMD_SUM = 3'd1;
   localparam logic [2:0] CMD_DIFF = 3'd2;
   localparam logic [2:0] CMD_SCALE = 3'd3;
   localparam logic [2:0] CMD_CONJ = 3'd4;
   localparam logic [2:0] CMD_MAG = 3'd5;
   localparam logic [2:0] CMD_NORM = 3'd6;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
endpackage

[design/qau_stream_if.sv]
`timescale 1ns / 1ps
interface qau_stream_if #(parameter int W = 16);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[design/quaternion_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Product, sum, difference, scale, conjugate and the unused code pass the lane registers
// and then the output register, one transaction per cycle while the result side keeps up
// and no magnitude or normalize transaction is busy. Magnitude and normalize run an
// iterative root and divider; no new transaction is taken until their result is registered.
// Magnitude or normalize waits while a lane transaction is in the first lane stage.
// Reset is synchronous, active high, and clears the valid flags and the sequencer.
module quaternion_arithmetic_unit #(
   parameter int COMP_WIDTH = qau_pkg::CompWidth,
   parameter int FRAC_BITS = qau_pkg::FracBits
) (
   input logic clock,
   input logic reset,
   qau_stream_if.sink req_if,
   qau_stream_if.source rsp_if
);
   import qau_pkg::*;
   localparam int CW = COMP_WIDTH;
   logic [2:0] cmd;
   logic signed [CW-1:0] a [4];
   logic signed [CW-1:0] b [4];
   logic signed [CW-1:0] k;
   assign cmd = req_if.data[9*CW+2 -: 3];
   always_comb
      for (int i = 0; i < 4; i++) begin
         a[i] = req_if.data[(8-i)*CW +: CW];
         b[i] = req_if.data[(4-i)*CW +: CW];
      end
   assign k = req_if.data[CW-1:0];
   logic v1_ff, vo_ff, go, take;
   logic slow, nbusy, ndone;
   logic [2:0] c1_ff;
   logic signed [CW-1:0] lr [4];
   logic ls [4];
   logic signed [CW-1:0] nr [4];
   logic [CW-1:0] nmag;
   logic nsat, ndz;
   logic [4*CW+CW+1:0] out_ff;
   assign slow = cmd == CMD_MAG || cmd == CMD_NORM;
   assign go = !vo_ff || rsp_if.ready;
   assign req_if.ready = go && !nbusy && !(v1_ff && slow);
   assign take = req_if.valid && req_if.ready;
   logic signed [CW-1:0] pa [4][4];
   logic signed [CW-1:0] pb [4][4];
   logic [3:0] pn [4];
   logic [2:0] lcmd;
   assign lcmd = (take && !slow) ? cmd : CMD_UNUSED;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pn[i] = '0;
         for (int j = 0; j < 4; j++) begin
            pa[i][j] = '0; pb[i][j] = '0;
         end
      end
      if (cmd == CMD_PRODUCT) begin
         pa[0] = '{a[0], a[1], a[2], a[3]}; pb[0] = '{b[0], b[1], b[2], b[3]}; pn[0] = 4'b1110;
         pa[1] = '{a[0], a[1], a[2], a[3]}; pb[1] = '{b[1], b[0], b[3], b[2]}; pn[1] = 4'b1000;
         pa[2] = '{a[0], a[2], a[3], a[1]}; pb[2] = '{b[2], b[0], b[1], b[3]}; pn[2] = 4'b1000;
         pa[3] = '{a[0], a[3], a[1], a[2]}; pb[3] = '{b[3], b[0], b[2], b[1]}; pn[3] = 4'b1000;
      end else if (cmd == CMD_SCALE) begin
         for (int i = 0; i < 4; i++) begin
            pa[i][0] = a[i]; pb[i][0] = k;
         end
      end else if (cmd == CMD_CONJ) begin
         pn[1] = 4'b0001; pn[2] = 4'b0001; pn[3] = 4'b0001;
      end
   end
   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_lane
         qau_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
            .clock(clock), .en(go), .cmd(lcmd),
            .a0(pa[g][0]), .a1(pa[g][1]), .a2(pa[g][2]), .a3(pa[g][3]),
            .b0(pb[g][0]), .b1(pb[g][1]), .b2(pb[g][2]), .b3(pb[g][3]),
            .neg(pn[g]), .a_self(a[g]), .b_self(b[g]), .r(lr[g]), .sat(ls[g]));
      end
   endgenerate
   qau_norm #(.CW(CW), .FB(FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .en(go && !v1_ff), .start(take && slow), .a(a),
      .busy(nbusy), .done(ndone), .r(nr), .mag(nmag), .sat(nsat), .dz(ndz));
   // The merge stage picks the lane results or the norm unit's result.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; vo_ff <= 1'b0;
      end else if (go) begin
         v1_ff <= take && !slow;
         vo_ff <= v1_ff || ndone;
      end
      if (take) c1_ff <= cmd;
      if (go) begin
         if (ndone && !v1_ff)
            out_ff <= {nr[0], nr[1], nr[2], nr[3],
                       (c1_ff == CMD_NORM && ndz) ? CW'(0) : nmag,
                       nsat && !(c1_ff == CMD_NORM && ndz),
                       c1_ff == CMD_NORM && ndz && 1'b1} &
                      {{(4*CW){c1_ff == CMD_NORM}}, {(CW+2){1'b1}}};
         else
            out_ff <= {lr[0], lr[1], lr[2], lr[3], CW'(0),
                       ls[0] | ls[1] | ls[2] | ls[3], 1'b0};
      end
   end
   assign rsp_if.valid = vo_ff;
   assign rsp_if.data = out_ff;
`ifndef SYNTHESIS
   a_no_merge_clash: assert property (@(posedge clock) disable iff (reset)
      !(v1_ff && ndone)) else $error("lane and norm results collide");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      nbusy |-> !req_if.ready) else $error("accept while norm busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.data))
      else $error("result changed while stalled");
`endif
endmodule

[design/qau_lane.sv]
`timescale 1ns / 1ps
module qau_lane #(
   parameter int CW = 16,
   parameter int FB = 14
) (
   input logic clock,
   input logic en,
   input logic [2:0] cmd,
   input logic signed [CW-1:0] a0, a1, a2, a3,
   input logic signed [CW-1:0] b0, b1, b2, b3,
   input logic [3:0] neg,
   input logic signed [CW-1:0] a_self, b_self,
   output logic signed [CW-1:0] r,
   output logic sat
);
   import qau_pkg::*;
   localparam int PW = 2 * CW;
   localparam int SW = PW + 3;
   logic signed [PW-1:0] p_ff [4];
   logic signed [PW-1:0] p_in [4];
   logic signed [CW+1:0] lin_ff, lin_in;
   logic [2:0] cmd_ff;
   logic signed [SW-1:0] s;
   logic signed [SW-1:0] rnd;
   logic signed [SW-1:0] v;
   always_comb begin
      p_in[0] = a0 * b0;
      p_in[1] = a1 * b1;
      p_in[2] = a2 * b2;
      p_in[3] = a3 * b3;
      case (cmd)
         CMD_SUM: lin_in = (CW+2)'(a_self) + (CW+2)'(b_self);
         CMD_DIFF: lin_in = (CW+2)'(a_self) - (CW+2)'(b_self);
         CMD_CONJ: lin_in = neg[0] ? -(CW+2)'(a_self) : (CW+2)'(a_self);
         default: lin_in = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++)
            p_ff[i] <= neg[i] ? -p_in[i] : p_in[i];
         lin_ff <= lin_in;
         cmd_ff <= cmd;
      end
   end
   always_comb begin
      s = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2]) + SW'(p_ff[3]);
      rnd = (s + (SW'(1) <<< (FB - 1))) >>> FB;
      if (cmd_ff == CMD_PRODUCT || cmd_ff == CMD_SCALE) v = rnd;
      else if (cmd_ff == CMD_SUM || cmd_ff == CMD_DIFF || cmd_ff == CMD_CONJ) v = SW'(lin_ff);
      else v = '0;
      sat = 1'b0;
      if (v > SW'((1 <<< (CW - 1)) - 1)) begin
         r = {1'b0, {(CW-1){1'b1}}};
         sat = 1'b1;
      end else if (v < -(SW'(1) <<< (CW - 1))) begin
         r = {1'b1, {(CW-1){1'b0}}};
         sat = 1'b1;
      end else r = v[CW-1:0];
   end
endmodule

[design/qau_norm.sv]
`timescale 1ns / 1ps
module qau_norm #(
   parameter int CW = 16,
   parameter int FB = 14
) (
   input logic clock,
   input logic reset,
   input logic en,
   input logic start,
   input logic signed [CW-1:0] a [4],
   output logic busy,
   output logic done,
   output logic signed [CW-1:0] r [4],
   output logic [CW-1:0] mag,
   output logic sat,
   output logic dz
);
   localparam int AW = 2 * CW + 2;
   localparam int RW = CW + 1;
   localparam int NW = CW + FB + 2;
   localparam int QW = FB + 3;
   localparam int SC = RW;
   localparam int DC = QW;
   localparam int CNT = $clog2(SC + DC + 2);
   logic [1:0] ph_ff, ph_in;
   localparam logic [1:0] PH_IDLE = 2'd0, PH_SQRT = 2'd1, PH_DIV = 2'd2, PH_DONE = 2'd3;
   logic [CNT-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [CW-1:0] mg_ff [4];
   logic [CW-1:0] mg_in [4];
   logic sg_ff [4];
   logic [NW-1:0] dr_ff [4];
   logic [NW-1:0] dr_in [4];
   logic [QW-1:0] q_ff [4];
   logic [QW-1:0] q_in [4];
   logic [AW-1:0] trial;
   logic [RW:0] m;
   assign busy = ph_ff != PH_IDLE;
   assign done = ph_ff == PH_DONE;
   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; acc_in = acc_ff; rem_in = rem_ff; root_in = root_ff;
      mg_in = mg_ff; dr_in = dr_ff; q_in = q_ff;
      m = (rem_ff > AW'(root_ff)) ? (RW+1)'(root_ff) + 1'b1 : (RW+1)'(root_ff);
      trial = {rem_ff[AW-3:0], acc_ff[AW-1 -: 2]};
      case (ph_ff)
         PH_IDLE: if (start) begin
            acc_in = '0;
            for (int i = 0; i < 4; i++) begin
               mg_in[i] = a[i][CW-1] ? CW'(-a[i]) : CW'(a[i]);
               acc_in = acc_in + AW'(mg_in[i]) * AW'(mg_in[i]);
            end
            rem_in = '0; root_in = '0; cnt_in = '0; ph_in = PH_SQRT;
         end
         PH_SQRT: begin
            // One root bit a cycle, restoring method.
            if (trial >= AW'({root_ff, 2'b01})) begin
               rem_in = trial - AW'({root_ff, 2'b01});
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            acc_in = acc_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT'(SC - 1)) begin
               ph_in = PH_DIV; cnt_in = '0;
            end
         end
         PH_DIV: begin
            if (cnt_ff == '0) begin
               // Remainder of the root decides rounding; m is now final.
               for (int i = 0; i < 4; i++) begin
                  dr_in[i] = NW'({mg_ff[i], {(FB+1){1'b0}}}) + NW'(m);
                  q_in[i] = '0;
               end
               root_in = m[RW-1:0];
               rem_in = AW'(m);
               cnt_in = cnt_ff + 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  if ((dr_ff[i] >> (DC - cnt_ff)) >= NW'(rem_ff[RW:0]) << 1) begin
                     dr_in[i] = dr_ff[i] - ((NW'(rem_ff[RW:0]) << 1) << (DC - cnt_ff));
                     q_in[i] = {q_ff[i][QW-2:0], 1'b1};
                  end else q_in[i] = {q_ff[i][QW-2:0], 1'b0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT'(DC)) ph_in = PH_DONE;
            end
         end
         default: if (en) ph_in = PH_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; cnt_ff <= '0;
      end else begin
         ph_ff <= ph_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; rem_ff <= rem_in; root_ff <= root_in;
      mg_ff <= mg_in; dr_ff <= dr_in; q_ff <= q_in;
      if (ph_ff == PH_IDLE && start)
         for (int i = 0; i < 4; i++) sg_ff[i] <= a[i][CW-1];
   end
   always_comb begin
      sat = 1'b0;
      dz = rem_ff[RW:0] == '0;
      for (int i = 0; i < 4; i++) begin
         if (dz) r[i] = '0;
         else if (!sg_ff[i] && q_ff[i] > QW'((1 <<< (CW - 1)) - 1)) begin
            r[i] = {1'b0, {(CW-1){1'b1}}}; sat = 1'b1;
         end else if (sg_ff[i] && q_ff[i] > QW'(1 <<< (CW - 1))) begin
            r[i] = {1'b1, {(CW-1){1'b0}}}; sat = 1'b1;
         end else r[i] = sg_ff[i] ? CW'(-q_ff[i]) : CW'(q_ff[i]);
      end
      if (|rem_ff[RW:CW]) begin
         mag = '1; sat = 1'b1;
      end else mag = rem_ff[CW-1:0];
   end
endmodule
